@@ hw/rtl/hma_pkg.sv @@
`default_nettype none

package hma_pkg;

  // Field widths
  localparam int PixW   = 8;
  localparam int GainW  = 16;
  localparam int HueNum = 6;
  localparam int ChanNum = 3;
  localparam int ProdW  = 2 * PixW;
  localparam int LvlProdW = PixW + GainW;
  localparam int SumW   = PixW + 3;

  // Hue enable bit positions
  localparam int HueR = 0;
  localparam int HueG = 1;
  localparam int HueB = 2;
  localparam int HueY = 3;
  localparam int HueM = 4;
  localparam int HueC = 5;

  // Color channel positions inside a channel vector
  localparam int ChR = 0;
  localparam int ChG = 1;
  localparam int ChB = 2;

  // Register reset values
  localparam logic [GainW-1:0]  GainReset = 16'd1024;
  localparam logic [HueNum-1:0] HueReset  = 6'd1;

  // Register map, indexed by paddr[2]
  typedef enum logic {
    REG_GAIN = 1'b0,
    REG_HUE  = 1'b1
  } reg_idx_e;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [HueNum-1:0][PixW-1:0] hue_vec_t;

  typedef struct packed {
    logic [GainW-1:0]  gain;
    logic [HueNum-1:0] en;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/hma_cfg.sv @@
`default_nettype none

module hma_cfg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output hma_pkg::cfg_t       cfg_o
);
  import hma_pkg::*;

  logic [GainW-1:0]  gain_q, gain_d;
  logic [HueNum-1:0] en_q, en_d;
  logic              wr_en;
  reg_idx_e          sel_reg;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign sel_reg = reg_idx_e'(paddr[2]);

  // Write decode
  always_comb begin
    gain_d = gain_q;
    en_d   = en_q;
    if (wr_en) begin
      unique case (sel_reg)
        REG_GAIN: gain_d = pwdata[GainW-1:0];
        REG_HUE:  en_d   = pwdata[HueNum-1:0];
        default:  gain_d = gain_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
      en_q   <= HueReset;
    end else begin
      gain_q <= gain_d;
      en_q   <= en_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (sel_reg)
      REG_GAIN: prdata = {{(32-GainW){1'b0}}, gain_q};
      REG_HUE:  prdata = {{(32-HueNum){1'b0}}, en_q};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.gain = gain_q;
  assign cfg_o.en   = en_q;

endmodule

`default_nettype wire

@@ hw/rtl/hma_premul.sv @@
`default_nettype none

// Stages 1-3: alpha products, divide by 255, hue dominance differences.
module hma_premul (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  hma_pkg::cfg_t       cfg_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  hma_pkg::pix_t       alpha_i,
  input  hma_pkg::pix_t       red_i,
  input  hma_pkg::pix_t       green_i,
  input  hma_pkg::pix_t       blue_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                out_zero_o,
  output hma_pkg::hue_vec_t   out_diff_o
);
  import hma_pkg::*;

  // own minus the larger of the other two, floored at zero
  function automatic pix_t pos_diff(pix_t own, pix_t oa, pix_t ob);
    pix_t mx;
    mx = (oa > ob) ? oa : ob;
    return (own > mx) ? pix_t'(own - mx) : '0;
  endfunction

  logic ymc;
  logic rdy1, rdy2, rdy3;

  logic                       v1_q, v2_q, v3_q;
  logic [ChanNum-1:0][ProdW-1:0] prod1_q, prod1_d;
  logic [ChanNum-1:0][PixW-1:0]  raw1_q;
  logic                       zero1_q, zero2_q, zero3_q;
  logic [ChanNum-1:0][PixW-1:0]  pl2_d, pl2_q, iv2_d, iv2_q;
  hue_vec_t                   diff3_d, diff3_q;
  logic [ChanNum-1:0][PixW-1:0]  raw_in;

  assign ymc = cfg_i.en[HueY] || cfg_i.en[HueM] || cfg_i.en[HueC];

  // Stage handshake chain
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Stage 1: select plain or inverted set, multiply by alpha
  assign raw_in[ChR] = red_i;
  assign raw_in[ChG] = green_i;
  assign raw_in[ChB] = blue_i;

  always_comb begin
    logic [PixW-1:0] sel;
    for (int k = 0; k < ChanNum; k++) begin
      // invert at 8 bits, 255 - c
      sel = ymc ? ~raw_in[k] : raw_in[k];
      prod1_d[k] = ProdW'(sel) * ProdW'(alpha_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      prod1_q <= prod1_d;
      raw1_q  <= raw_in;
      zero1_q <= (alpha_i == '0);
    end
  end

  // Stage 2: round(x/255) = floor(y/255), y = x+127, via shift-add
  always_comb begin
    logic [ProdW-1:0] y;
    logic [ProdW-1:0] s;
    for (int k = 0; k < ChanNum; k++) begin
      y = prod1_q[k] + ProdW'(127);
      s = y + (y >> PixW) + ProdW'(1);
      iv2_d[k] = s[ProdW-1:PixW];
      // R, G, B keep the unscaled plain color when Y, M or C is on
      pl2_d[k] = ymc ? raw1_q[k] : s[ProdW-1:PixW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pl2_q   <= pl2_d;
      iv2_q   <= iv2_d;
      zero2_q <= zero1_q;
    end
  end

  // Stage 3: dominance differences per hue
  always_comb begin
    diff3_d[HueR] = pos_diff(pl2_q[ChR], pl2_q[ChB], pl2_q[ChG]);
    diff3_d[HueG] = pos_diff(pl2_q[ChG], pl2_q[ChB], pl2_q[ChR]);
    diff3_d[HueB] = pos_diff(pl2_q[ChB], pl2_q[ChG], pl2_q[ChR]);
    diff3_d[HueY] = pos_diff(iv2_q[ChB], iv2_q[ChG], iv2_q[ChR]);
    diff3_d[HueM] = pos_diff(iv2_q[ChG], iv2_q[ChB], iv2_q[ChR]);
    diff3_d[HueC] = pos_diff(iv2_q[ChR], iv2_q[ChB], iv2_q[ChG]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      diff3_q <= diff3_d;
      zero3_q <= zero2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_zero_o  = zero3_q;
  assign out_diff_o  = diff3_q;

endmodule

`default_nettype wire

@@ hw/rtl/hma_level.sv @@
`default_nettype none

// Stages 4-5: gain multiply, then round, clamp and enable mask.
module hma_level (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  hma_pkg::cfg_t       cfg_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 in_zero_i,
  input  hma_pkg::hue_vec_t   in_diff_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                out_zero_o,
  output hma_pkg::hue_vec_t   out_lvl_o
);
  import hma_pkg::*;

  logic rdy4, rdy5;
  logic v4_q, v5_q;
  logic zero4_q, zero5_q;
  logic [HueNum-1:0][LvlProdW-1:0] prod4_d, prod4_q;
  hue_vec_t lvl5_d, lvl5_q;

  assign rdy5       = !v5_q || out_ready_i;
  assign rdy4       = !v4_q || rdy5;
  assign in_ready_o = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_valid_i;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage 4: difference times gain
  always_comb begin
    for (int k = 0; k < HueNum; k++) begin
      prod4_d[k] = LvlProdW'(in_diff_i[k]) * LvlProdW'(cfg_i.gain);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) begin
      prod4_q <= prod4_d;
      zero4_q <= in_zero_i;
    end
  end

  // Stage 5: half-up rounding, cap at 255, drop disabled hues
  always_comb begin
    logic [LvlProdW-1:0] rnd;
    for (int k = 0; k < HueNum; k++) begin
      rnd = prod4_q[k] + LvlProdW'(512);
      if (!cfg_i.en[k]) begin
        lvl5_d[k] = '0;
      end else if (|rnd[LvlProdW-1:PixW+10]) begin
        lvl5_d[k] = '1;
      end else begin
        lvl5_d[k] = rnd[PixW+9:10];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      lvl5_q  <= lvl5_d;
      zero5_q <= zero4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign out_zero_o  = zero5_q;
  assign out_lvl_o   = lvl5_q;

endmodule

`default_nettype wire

@@ hw/rtl/hma_acc.sv @@
`default_nettype none

// Stage 6: saturating sum of hue levels into the output register; a zero-alpha pixel gives 0.
module hma_acc (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 in_zero_i,
  input  hma_pkg::hue_vec_t   in_lvl_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output hma_pkg::pix_t       mask_alpha_o
);
  import hma_pkg::*;

  logic        v_q;
  pix_t        mask_q, mask_d;
  logic [SumW-1:0] sum;

  assign in_ready_o = !v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  // Levels are never negative, so capping the full sum at 255 equals saturating
  always_comb begin
    sum = '0;
    for (int k = 0; k < HueNum; k++) begin
      sum = sum + SumW'(in_lvl_i[k]);
    end
    if (in_zero_i) begin
      mask_d = '0;
    end else if (|sum[SumW-1:PixW]) begin
      mask_d = '1;
    end else begin
      mask_d = sum[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mask_q <= mask_d;
    end
  end

  assign out_valid_o  = v_q;
  assign mask_alpha_o = mask_q;

endmodule

`default_nettype wire

@@ hw/rtl/rgb_hue_mask_alpha.sv @@
// Channel  | Handshake                | Payload
// ---------+--------------------------+-----------------------------------------
// in       | in_valid_i / in_stall_o  | alpha_in_i, red_in_i, green_in_i, blue_in_i
// out      | out_valid_o / out_stall_i| mask_alpha_o
// cfg      | APB psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One pixel per clock while the output is not stalled; the pipeline register stages are
// alpha product, divide by 255, differences, gain product, round and sum.
// rst_ni clears all stage valid bits asynchronously; registers reset to
// gain 1024 and hue enables 1.
// A stall on the output backs up stage by stage; empty stages still fill.
`default_nettype none

module rgb_hue_mask_alpha (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  hma_pkg::pix_t       alpha_in_i,
  input  hma_pkg::pix_t       red_in_i,
  input  hma_pkg::pix_t       green_in_i,
  input  hma_pkg::pix_t       blue_in_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output hma_pkg::pix_t       mask_alpha_o
);
  import hma_pkg::*;

  cfg_t     cfg;
  logic     in_ready;
  logic     pm_valid, pm_ready, pm_zero;
  hue_vec_t pm_diff;
  logic     lv_valid, lv_ready, lv_zero;
  hue_vec_t lv_lvl;

  hma_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hma_premul u_premul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .alpha_i     (alpha_in_i),
    .red_i       (red_in_i),
    .green_i     (green_in_i),
    .blue_i      (blue_in_i),
    .out_valid_o (pm_valid),
    .out_ready_i (pm_ready),
    .out_zero_o  (pm_zero),
    .out_diff_o  (pm_diff)
  );

  hma_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (pm_valid),
    .in_ready_o  (pm_ready),
    .in_zero_i   (pm_zero),
    .in_diff_i   (pm_diff),
    .out_valid_o (lv_valid),
    .out_ready_i (lv_ready),
    .out_zero_o  (lv_zero),
    .out_lvl_o   (lv_lvl)
  );

  hma_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (lv_valid),
    .in_ready_o   (lv_ready),
    .in_zero_i    (lv_zero),
    .in_lvl_i     (lv_lvl),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mask_alpha_o (mask_alpha_o)
  );

  assign in_stall_o = !in_ready;

endmodule

`default_nettype wire

@@ hw/rtl/hma_checker.sv @@
`default_nettype none

module hma_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire [7:0]  alpha_in_i,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [7:0]  mask_alpha_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mask_alpha_o))
    else $error("result changed while stalled");

  // Input backpressure only comes from a full pipe behind a stalled output
  a_in_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Zero-alpha pixel comes out as zero when the output is not stalled on its way
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && alpha_in_i == 8'd0)
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o && mask_alpha_o == 8'd0)
    else $error("zero-alpha pixel gave nonzero mask");

endmodule

bind rgb_hue_mask_alpha hma_checker u_hma_checker (.*);

`default_nettype wire
